// ===== rtl/vdcs_pkg.sv =====
// shared types, constants and helper functions of the verlet constraint solver
package vdcs_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int INDEX_W           = 10;
    localparam int CFG_ADDR_W        = 2;
    localparam int CFG_DATA_W        = 32;
    localparam int DIVIDEND_W        = 49;
    localparam int DIVISOR_W         = 33;
    localparam int QUOT_W            = 18;
    localparam int RADICAND_W        = 64;
    localparam int ROOT_W            = 32;
    localparam int MUL_A_W           = 35;
    localparam int MUL_B_W           = 34;
    localparam int PROD_W            = MUL_A_W + MUL_B_W;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;

    localparam logic [31:0]        DT_SQ_RESET = 32'd18;
    localparam logic signed [31:0] GX_RESET    = 32'sd0;
    localparam logic signed [31:0] GY_RESET    = -32'sd642908;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_INTEG  = 2'd1;
    localparam logic [1:0] MODE_CONSTR = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_DT_SQ = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GX    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GY    = 2'd2;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic [31:0]        mass;
        logic               pinned;
    } t_particle;

    localparam int PART_W = $bits(t_particle);

    typedef enum logic [4:0] {
        S_IDLE, S_LATA, S_LATB,
        S_INT_X, S_INT_Y, S_INT_W,
        S_C_DIFF, S_C_ABS, S_C_SQX, S_C_SQY, S_C_SUM, S_C_ROOT, S_C_ERR,
        S_NX_GO, S_NX_WT, S_NY_GO, S_NY_WT,
        S_WA_GO, S_WA_WT, S_WB_GO, S_WB_WT,
        S_C_MX, S_C_MY, S_C_AX, S_C_AY, S_C_BX, S_C_BY, S_C_WA, S_C_WB
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // clamp quotient magnitude to one and apply the sign of the difference
    function automatic logic signed [17:0] unit_part(input logic [QUOT_W-1:0] q,
                                                     input logic neg);
        logic [16:0] m;
        logic signed [17:0] r;
        m = (q > 18'(ONE_Q16)) ? ONE_Q16 : q[16:0];
        r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return r;
    endfunction

endpackage

// ===== rtl/verlet_distance_constraint_solver.sv =====
// top level: particle memory, sequencer and datapath of the verlet constraint solver
//
// channel  | direction | handshake            | payload
// command  | in        | start, busy          | i_mode, i_index_a/b, i_in_*, i_min/max_length
// result   | out       | o_valid (strobe)     | o_out_pos_x/y, o_out_prev_x/y, o_out_mass, o_out_pinned
// config   | in        | i_cfg_we             | i_cfg_addr, i_cfg_wdata
//
// a write is stored in the cycle it is taken; it, like a word with a bad index, leaves busy low
// constraint skips the two weight divisions if a particle is pinned or the mass sum is zero,
// and stops after the error check if the distance or the error is zero; its time is set by
// the 32-step root and the 18-step divisions; busy is high from the cycle after any other word
// is taken until the sequencer is idle again; reset is synchronous and active low; the memory
// holds no reset value; o_valid marks a read word for one cycle; the receiver cannot stall
module verlet_distance_constraint_solver #(
    parameter int MAX_PARTICLES = vdcs_pkg::MAX_PARTICLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_mode,
    input  logic [vdcs_pkg::INDEX_W-1:0]        i_index_a,
    input  logic [vdcs_pkg::INDEX_W-1:0]        i_index_b,
    input  logic signed [31:0]                  i_in_pos_x,
    input  logic signed [31:0]                  i_in_pos_y,
    input  logic [31:0]                         i_in_mass,
    input  logic                                i_in_pinned,
    input  logic [30:0]                         i_min_length,
    input  logic [30:0]                         i_max_length,
    input  logic                                i_cfg_we,
    input  logic [vdcs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [vdcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [31:0]                  o_out_pos_x,
    output logic signed [31:0]                  o_out_pos_y,
    output logic signed [31:0]                  o_out_prev_x,
    output logic signed [31:0]                  o_out_prev_y,
    output logic [31:0]                         o_out_mass,
    output logic                                o_out_pinned
);
    localparam int AW = $clog2(MAX_PARTICLES);

    vdcs_pkg::t_state r_state, n_state;

    logic [31:0]        r_dt;
    logic signed [31:0] r_gx, r_gy;

    logic [1:0]          r_mode;
    logic [AW-1:0]       r_ia, r_ib;
    logic [30:0]         r_lo, r_hi;
    vdcs_pkg::t_particle r_pa, r_pb, r_out;
    logic                r_valid;

    logic signed [vdcs_pkg::PROD_W-1:0] r_prod;
    logic signed [31:0] r_newx;
    logic signed [32:0] r_dx, r_dy;
    logic [32:0]        r_adx, r_ady;
    logic [31:0]        r_ux, r_uy;
    logic               r_s;
    logic [63:0]        r_acc;
    logic [32:0]        r_dist;
    logic signed [33:0] r_err;
    logic               r_needdiv;
    logic signed [17:0] r_nx, r_ny;
    logic [16:0]        r_wa, r_wb;
    logic signed [34:0] r_delx, r_dely;
    logic signed [31:0] r_nax, r_nay, r_nbx, r_nby;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    vdcs_pkg::t_particle  ram_wdata, ram_rdata;
    logic [vdcs_pkg::PART_W-1:0] ram_rbits;

    logic signed [vdcs_pkg::MUL_A_W-1:0] m_a;
    logic signed [vdcs_pkg::MUL_B_W-1:0] m_b;
    logic signed [vdcs_pkg::PROD_W-1:0]  c_prod, c_sh;

    logic                                div_start, div_done;
    logic [vdcs_pkg::DIVIDEND_W-1:0]     div_dividend;
    logic [vdcs_pkg::DIVISOR_W-1:0]      div_divisor;
    logic [vdcs_pkg::QUOT_W-1:0]         div_quot;
    logic                                sq_start, sq_done;
    logic [vdcs_pkg::RADICAND_W-1:0]     sq_radicand;
    logic [vdcs_pkg::ROOT_W-1:0]         sq_root;

    logic                accept, ok_a, ok_b;
    logic [AW-1:0]       c_ia, c_ib;
    logic [32:0]         c_adx, c_ady;
    logic                c_s;
    logic signed [33:0]  c_d34, c_lo34, c_hi34, c_err;
    logic [32:0]         c_sum;
    logic signed [31:0]  c_newy;
    logic signed [49:0]  c_acc50;

    assign accept = start && (r_state == vdcs_pkg::S_IDLE);
    assign busy   = (r_state != vdcs_pkg::S_IDLE);
    assign ok_a   = (32'(i_index_a) < 32'(MAX_PARTICLES));
    assign ok_b   = (32'(i_index_b) < 32'(MAX_PARTICLES));
    assign c_ia   = AW'(32'(i_index_a));
    assign c_ib   = AW'(32'(i_index_b));

    assign c_prod  = m_a * m_b;
    assign c_sh    = r_prod >>> 16;
    assign c_acc50 = $signed(c_sh[49:0]);

    assign c_adx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign c_ady = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign c_s   = c_adx[32] | c_adx[31] | c_ady[32] | c_ady[31];

    assign c_d34  = $signed({1'b0, r_dist});
    assign c_lo34 = $signed({3'b0, r_lo});
    assign c_hi34 = $signed({3'b0, r_hi});
    assign c_err  = (c_d34 < c_lo34) ? c_d34 - c_lo34 :
                    (c_d34 > c_hi34) ? c_d34 - c_hi34 : 34'sd0;
    assign c_sum  = {1'b0, r_pa.mass} + {1'b0, r_pb.mass};

    assign c_newy = vdcs_pkg::sat32((50'(r_pa.cur_y) <<< 1) - 50'(r_pa.prev_y) + c_acc50);

    assign ram_rdata = vdcs_pkg::t_particle'(ram_rbits);

    vdcs_ram #(
        .WIDTH (vdcs_pkg::PART_W),
        .DEPTH (MAX_PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    vdcs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_radicand),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    vdcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vdcs_pkg::S_IDLE: begin
                if (start) begin
                    if ((i_mode == vdcs_pkg::MODE_READ || i_mode == vdcs_pkg::MODE_INTEG) && ok_a) begin
                        n_state = vdcs_pkg::S_LATA;
                    end else if (i_mode == vdcs_pkg::MODE_CONSTR && ok_a && ok_b) begin
                        n_state = vdcs_pkg::S_LATA;
                    end
                end
            end
            vdcs_pkg::S_LATA: begin
                if (r_mode == vdcs_pkg::MODE_READ) begin
                    n_state = vdcs_pkg::S_IDLE;
                end else if (r_mode == vdcs_pkg::MODE_INTEG) begin
                    n_state = vdcs_pkg::S_INT_X;
                end else begin
                    n_state = vdcs_pkg::S_LATB;
                end
            end
            vdcs_pkg::S_LATB:   n_state = vdcs_pkg::S_C_DIFF;
            vdcs_pkg::S_INT_X:  n_state = vdcs_pkg::S_INT_Y;
            vdcs_pkg::S_INT_Y:  n_state = vdcs_pkg::S_INT_W;
            vdcs_pkg::S_INT_W:  n_state = vdcs_pkg::S_IDLE;
            vdcs_pkg::S_C_DIFF: n_state = vdcs_pkg::S_C_ABS;
            vdcs_pkg::S_C_ABS:  n_state = vdcs_pkg::S_C_SQX;
            vdcs_pkg::S_C_SQX:  n_state = vdcs_pkg::S_C_SQY;
            vdcs_pkg::S_C_SQY:  n_state = vdcs_pkg::S_C_SUM;
            vdcs_pkg::S_C_SUM:  n_state = vdcs_pkg::S_C_ROOT;
            vdcs_pkg::S_C_ROOT: begin
                if (sq_done) begin
                    n_state = vdcs_pkg::S_C_ERR;
                end
            end
            vdcs_pkg::S_C_ERR: begin
                if (r_dist == 33'd0 || c_err == 34'sd0) begin
                    n_state = vdcs_pkg::S_IDLE;
                end else begin
                    n_state = vdcs_pkg::S_NX_GO;
                end
            end
            vdcs_pkg::S_NX_GO: n_state = vdcs_pkg::S_NX_WT;
            vdcs_pkg::S_NX_WT: begin
                if (div_done) begin
                    n_state = vdcs_pkg::S_NY_GO;
                end
            end
            vdcs_pkg::S_NY_GO: n_state = vdcs_pkg::S_NY_WT;
            vdcs_pkg::S_NY_WT: begin
                if (div_done) begin
                    n_state = r_needdiv ? vdcs_pkg::S_WA_GO : vdcs_pkg::S_C_MX;
                end
            end
            vdcs_pkg::S_WA_GO: n_state = vdcs_pkg::S_WA_WT;
            vdcs_pkg::S_WA_WT: begin
                if (div_done) begin
                    n_state = vdcs_pkg::S_WB_GO;
                end
            end
            vdcs_pkg::S_WB_GO: n_state = vdcs_pkg::S_WB_WT;
            vdcs_pkg::S_WB_WT: begin
                if (div_done) begin
                    n_state = vdcs_pkg::S_C_MX;
                end
            end
            vdcs_pkg::S_C_MX: n_state = vdcs_pkg::S_C_MY;
            vdcs_pkg::S_C_MY: n_state = vdcs_pkg::S_C_AX;
            vdcs_pkg::S_C_AX: n_state = vdcs_pkg::S_C_AY;
            vdcs_pkg::S_C_AY: n_state = vdcs_pkg::S_C_BX;
            vdcs_pkg::S_C_BX: n_state = vdcs_pkg::S_C_BY;
            vdcs_pkg::S_C_BY: n_state = vdcs_pkg::S_C_WA;
            vdcs_pkg::S_C_WA: n_state = vdcs_pkg::S_C_WB;
            vdcs_pkg::S_C_WB: n_state = vdcs_pkg::S_IDLE;
            default:          n_state = vdcs_pkg::S_IDLE;
        endcase
    end

    // memory, multiplier and unit controls
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = r_ia;
        ram_wdata    = r_pa;
        ram_raddr    = r_ia;
        m_a          = '0;
        m_b          = '0;
        div_start    = 1'b0;
        div_dividend = {r_adx, 16'd0};
        div_divisor  = r_dist;
        sq_start     = 1'b0;
        sq_radicand  = r_acc + r_prod[63:0];
        case (r_state)
            vdcs_pkg::S_IDLE: begin
                ram_raddr = c_ia;
                ram_waddr = c_ia;
                ram_we    = accept && (i_mode == vdcs_pkg::MODE_WRITE) && ok_a;
                ram_wdata = '{cur_x: i_in_pos_x, cur_y: i_in_pos_y, prev_x: i_in_pos_x,
                              prev_y: i_in_pos_y, mass: i_in_mass, pinned: i_in_pinned};
            end
            vdcs_pkg::S_LATA: ram_raddr = r_ib;
            vdcs_pkg::S_INT_X: begin
                m_a = 35'(r_dt);
                m_b = 34'(r_gx);
            end
            vdcs_pkg::S_INT_Y: begin
                m_a = 35'(r_dt);
                m_b = 34'(r_gy);
            end
            vdcs_pkg::S_INT_W: begin
                ram_we = 1'b1;
                ram_wdata.prev_x = r_pa.cur_x;
                ram_wdata.prev_y = r_pa.cur_y;
                if (!r_pa.pinned) begin
                    ram_wdata.cur_x = r_newx;
                    ram_wdata.cur_y = c_newy;
                end
            end
            vdcs_pkg::S_C_SQX: begin
                m_a = 35'(r_ux);
                m_b = 34'(r_ux);
            end
            vdcs_pkg::S_C_SQY: begin
                m_a = 35'(r_uy);
                m_b = 34'(r_uy);
            end
            vdcs_pkg::S_C_SUM: sq_start = 1'b1;
            vdcs_pkg::S_NX_GO: div_start = 1'b1;
            vdcs_pkg::S_NY_GO: begin
                div_start    = 1'b1;
                div_dividend = {r_ady, 16'd0};
            end
            vdcs_pkg::S_WA_GO: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, r_pb.mass, 16'd0};
                div_divisor  = c_sum;
            end
            vdcs_pkg::S_WB_GO: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, r_pa.mass, 16'd0};
                div_divisor  = c_sum;
            end
            vdcs_pkg::S_C_MX: begin
                m_a = 35'(r_nx);
                m_b = r_err;
            end
            vdcs_pkg::S_C_MY: begin
                m_a = 35'(r_ny);
                m_b = r_err;
            end
            vdcs_pkg::S_C_AX: begin
                m_a = r_delx;
                m_b = 34'(r_wa);
            end
            vdcs_pkg::S_C_AY: begin
                m_a = r_dely;
                m_b = 34'(r_wa);
            end
            vdcs_pkg::S_C_BX: begin
                m_a = r_delx;
                m_b = 34'(r_wb);
            end
            vdcs_pkg::S_C_BY: begin
                m_a = r_dely;
                m_b = 34'(r_wb);
            end
            vdcs_pkg::S_C_WA: begin
                ram_we          = 1'b1;
                ram_wdata.cur_x = r_nax;
                ram_wdata.cur_y = r_nay;
            end
            vdcs_pkg::S_C_WB: begin
                ram_we          = 1'b1;
                ram_waddr       = r_ib;
                ram_wdata       = r_pb;
                ram_wdata.cur_x = r_nbx;
                ram_wdata.cur_y = r_nby;
            end
            default: ;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdcs_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_dt    <= vdcs_pkg::DT_SQ_RESET;
            r_gx    <= vdcs_pkg::GX_RESET;
            r_gy    <= vdcs_pkg::GY_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && i_mode == vdcs_pkg::MODE_READ && !ok_a) ||
                       (r_state == vdcs_pkg::S_LATA && r_mode == vdcs_pkg::MODE_READ);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    vdcs_pkg::REG_DT_SQ: r_dt <= i_cfg_wdata;
                    vdcs_pkg::REG_GX:    r_gx <= $signed(i_cfg_wdata);
                    vdcs_pkg::REG_GY:    r_gy <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= c_prod;
        if (accept) begin
            r_mode <= i_mode;
            r_ia   <= c_ia;
            r_ib   <= c_ib;
            r_lo   <= i_min_length;
            r_hi   <= i_max_length;
            if (i_mode == vdcs_pkg::MODE_READ && !ok_a) begin
                r_out <= '0;
            end
        end
        case (r_state)
            vdcs_pkg::S_LATA: begin
                r_pa <= ram_rdata;
                if (r_mode == vdcs_pkg::MODE_READ) begin
                    r_out <= ram_rdata;
                end
            end
            vdcs_pkg::S_LATB: r_pb <= ram_rdata;
            vdcs_pkg::S_INT_Y: begin
                r_newx <= vdcs_pkg::sat32((50'(r_pa.cur_x) <<< 1) - 50'(r_pa.prev_x) + c_acc50);
            end
            vdcs_pkg::S_C_DIFF: begin
                r_dx <= 33'(r_pa.cur_x) - 33'(r_pb.cur_x);
                r_dy <= 33'(r_pa.cur_y) - 33'(r_pb.cur_y);
            end
            vdcs_pkg::S_C_ABS: begin
                r_adx <= c_adx;
                r_ady <= c_ady;
                r_s   <= c_s;
                r_ux  <= c_s ? c_adx[32:1] : c_adx[31:0];
                r_uy  <= c_s ? c_ady[32:1] : c_ady[31:0];
            end
            vdcs_pkg::S_C_SQY: r_acc <= r_prod[63:0];
            vdcs_pkg::S_C_ROOT: begin
                if (sq_done) begin
                    r_dist <= {1'b0, sq_root} << r_s;
                end
            end
            vdcs_pkg::S_C_ERR: begin
                r_err     <= c_err;
                r_needdiv <= 1'b0;
                if (r_pa.pinned && r_pb.pinned) begin
                    r_wa <= '0;
                    r_wb <= '0;
                end else if (r_pa.pinned) begin
                    r_wa <= '0;
                    r_wb <= vdcs_pkg::ONE_Q16;
                end else if (r_pb.pinned) begin
                    r_wa <= vdcs_pkg::ONE_Q16;
                    r_wb <= '0;
                end else if (c_sum == 33'd0) begin
                    r_wa <= vdcs_pkg::HALF_Q16;
                    r_wb <= vdcs_pkg::HALF_Q16;
                end else begin
                    r_needdiv <= 1'b1;
                end
            end
            vdcs_pkg::S_NX_WT: begin
                if (div_done) begin
                    r_nx <= vdcs_pkg::unit_part(div_quot, r_dx[32]);
                end
            end
            vdcs_pkg::S_NY_WT: begin
                if (div_done) begin
                    r_ny <= vdcs_pkg::unit_part(div_quot, r_dy[32]);
                end
            end
            vdcs_pkg::S_WA_WT: begin
                if (div_done) begin
                    r_wa <= div_quot[16:0];
                end
            end
            vdcs_pkg::S_WB_WT: begin
                if (div_done) begin
                    r_wb <= div_quot[16:0];
                end
            end
            vdcs_pkg::S_C_MY: r_delx <= c_sh[34:0];
            vdcs_pkg::S_C_AX: r_dely <= c_sh[34:0];
            vdcs_pkg::S_C_AY: r_nax  <= vdcs_pkg::sat32(50'(r_pa.cur_x) - c_acc50);
            vdcs_pkg::S_C_BX: r_nay  <= vdcs_pkg::sat32(50'(r_pa.cur_y) - c_acc50);
            vdcs_pkg::S_C_BY: r_nbx  <= vdcs_pkg::sat32(50'(r_pb.cur_x) + c_acc50);
            vdcs_pkg::S_C_WA: r_nby  <= vdcs_pkg::sat32(50'(r_pb.cur_y) + c_acc50);
            default: ;
        endcase
    end

    assign o_valid      = r_valid;
    assign o_out_pos_x  = r_out.cur_x;
    assign o_out_pos_y  = r_out.cur_y;
    assign o_out_prev_x = r_out.prev_x;
    assign o_out_prev_y = r_out.prev_y;
    assign o_out_mass   = r_out.mass;
    assign o_out_pinned = r_out.pinned;
endmodule

// ===== rtl/vdcs_ram.sv =====
// generic single-write, single-read ram with registered read data
module vdcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/vdcs_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module vdcs_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vdcs_pkg::RADICAND_W-1:0]   i_radicand,
    output logic                              o_done,
    output logic [vdcs_pkg::ROOT_W-1:0]       o_root
);
    logic [63:0] r_n, n_n;
    logic [63:0] r_res, n_res;
    logic [4:0]  r_k;
    logic        r_busy;
    logic        r_done;
    logic [63:0] c_bit;
    logic [64:0] c_trial;

    always_comb begin
        c_bit   = 64'd1 << {r_k, 1'b0};
        c_trial = {1'b0, r_res} + {1'b0, c_bit};
        if ({1'b0, r_n} >= c_trial) begin
            n_n   = r_n - c_trial[63:0];
            n_res = (r_res >> 1) + c_bit;
        end else begin
            n_n   = r_n;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 5'd31;
            end else if (r_busy) begin
                r_k <= r_k - 5'd1;
                if (r_k == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_res <= '0;
        end else if (r_busy) begin
            r_n   <= n_n;
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
endmodule

// ===== rtl/vdcs_div.sv =====
// restoring divider, one quotient bit per cycle
module vdcs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vdcs_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [vdcs_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [vdcs_pkg::QUOT_W-1:0]       o_quot
);
    localparam int DEN_W = vdcs_pkg::DIVISOR_W + vdcs_pkg::QUOT_W;

    logic [vdcs_pkg::DIVIDEND_W-1:0] r_rem;
    logic [DEN_W-1:0]                r_den;
    logic [vdcs_pkg::QUOT_W-1:0]     r_q;
    logic [4:0]                      r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic                            c_ge;

    assign c_ge = (DEN_W'(r_rem) >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(vdcs_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= DEN_W'(i_divisor) << (vdcs_pkg::QUOT_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (c_ge) begin
                r_rem <= r_rem - r_den[vdcs_pkg::DIVIDEND_W-1:0];
            end
            r_q   <= {r_q[vdcs_pkg::QUOT_W-2:0], c_ge};
            r_den <= r_den >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== sim/verlet_distance_constraint_solver_test.sv =====
// testbench of the verlet constraint solver: directed table, random phases, predicted reads
module verlet_distance_constraint_solver_test;

    typedef struct {
        logic [1:0]         mode;
        logic [9:0]         a;
        logic [9:0]         b;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        mass;
        logic               pin;
        logic [30:0]        lo;
        logic [30:0]        hi;
    } t_word;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic [31:0]        mass;
        logic               pin;
    } t_snapshot;

    typedef struct {
        t_word     w;
        bit        typed;
        t_snapshot exp;
    } t_row;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = vdcs_pkg::MODE_WRITE;
    logic [9:0]         i_index_a = '0;
    logic [9:0]         i_index_b = '0;
    logic signed [31:0] i_in_pos_x = '0;
    logic signed [31:0] i_in_pos_y = '0;
    logic [31:0]        i_in_mass = '0;
    logic               i_in_pinned = 1'b0;
    logic [30:0]        i_min_length = '0;
    logic [30:0]        i_max_length = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = vdcs_pkg::REG_DT_SQ;
    logic [31:0]        i_cfg_wdata = '0;
    logic               o_valid;
    logic signed [31:0] o_out_pos_x;
    logic signed [31:0] o_out_pos_y;
    logic signed [31:0] o_out_prev_x;
    logic signed [31:0] o_out_prev_y;
    logic [31:0]        o_out_mass;
    logic               o_out_pinned;

    // predictor state
    t_snapshot          mem [1024];
    bit                 written [1024];
    logic [31:0]        dt_sq;
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;

    t_snapshot          pending_reads [$];
    t_row               plan [$];
    int                 errors = 0;
    int                 idle_cycles = 0;

    verlet_distance_constraint_solver u_dut (.*);

    always #2 i_clk = ~i_clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_snapshot e;
        if (i_rst_n && o_valid) begin
            if (pending_reads.size() == 0) begin
                report("unexpected word", o_out_pos_x, 32'h0);
            end else begin
                e = pending_reads.pop_front();
                if (o_out_pos_x !== e.px) report("pos_x", o_out_pos_x, e.px);
                if (o_out_pos_y !== e.py) report("pos_y", o_out_pos_y, e.py);
                if (o_out_prev_x !== e.qx) report("prev_x", o_out_prev_x, e.qx);
                if (o_out_prev_y !== e.qy) report("prev_y", o_out_prev_y, e.qy);
                if (o_out_mass !== e.mass) report("mass", o_out_mass, e.mass);
                if (o_out_pinned !== e.pin) report("pinned", {31'b0, o_out_pinned}, {31'b0, e.pin});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_of(input longint d, input longint span);
        longint n;
        n = (d * 65536) / span;
        if (n > 65536) n = 65536;
        if (n < -65536) n = -65536;
        return n;
    endfunction

    function automatic void step_particle(input int i);
        longint ox, oy, ax, ay;
        ox = mem[i].px;
        oy = mem[i].py;
        if (!mem[i].pin) begin
            ax = (longint'({32'd0, dt_sq}) * longint'(grav_x)) >>> 16;
            ay = (longint'({32'd0, dt_sq}) * longint'(grav_y)) >>> 16;
            mem[i].px = clip32(2 * ox - longint'(mem[i].qx) + ax);
            mem[i].py = clip32(2 * oy - longint'(mem[i].qy) + ay);
        end
        mem[i].qx = ox;
        mem[i].qy = oy;
    endfunction

    function automatic void relax_pair(input int a, input int b, input longint lo,
                                       input longint hi);
        longint dx, dy, span, err, wa, wb, delx, dely;
        longint unsigned ux, uy, sum;
        int s;
        dx = longint'(mem[a].px) - longint'(mem[b].px);
        dy = longint'(mem[a].py) - longint'(mem[b].py);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        s = (ux >= 64'h80000000 || uy >= 64'h80000000) ? 1 : 0;
        ux >>= s;
        uy >>= s;
        span = root64(ux * ux + uy * uy) << s;
        if (span == 0) return;
        err = 0;
        if (span < lo) err = span - lo;
        else if (span > hi) err = span - hi;
        if (err == 0) return;
        if (mem[a].pin && mem[b].pin) begin
            wa = 0; wb = 0;
        end else if (mem[a].pin) begin
            wa = 0; wb = 65536;
        end else if (mem[b].pin) begin
            wa = 65536; wb = 0;
        end else begin
            sum = longint'(mem[a].mass) + longint'(mem[b].mass);
            if (sum == 0) begin
                wa = 32768; wb = 32768;
            end else begin
                wa = (longint'(mem[b].mass) << 16) / sum;
                wb = (longint'(mem[a].mass) << 16) / sum;
            end
        end
        delx = (unit_of(dx, span) * err) >>> 16;
        dely = (unit_of(dy, span) * err) >>> 16;
        mem[a].px = clip32(longint'(mem[a].px) - ((delx * wa) >>> 16));
        mem[a].py = clip32(longint'(mem[a].py) - ((dely * wa) >>> 16));
        mem[b].px = clip32(longint'(mem[b].px) + ((delx * wb) >>> 16));
        mem[b].py = clip32(longint'(mem[b].py) + ((dely * wb) >>> 16));
    endfunction

    // drives one word, waits for it to be taken, then updates the predictor
    task automatic send(input t_word w, input int gap_pct, input bit typed, input t_snapshot exp);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_mode       <= w.mode;
        i_index_a    <= w.a;
        i_index_b    <= w.b;
        i_in_pos_x   <= w.px;
        i_in_pos_y   <= w.py;
        i_in_mass    <= w.mass;
        i_in_pinned  <= w.pin;
        i_min_length <= w.lo;
        i_max_length <= w.hi;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        case (w.mode)
            vdcs_pkg::MODE_WRITE: begin
                mem[w.a] = '{w.px, w.py, w.px, w.py, w.mass, w.pin};
                written[w.a] = 1'b1;
            end
            vdcs_pkg::MODE_INTEG:  step_particle(w.a);
            vdcs_pkg::MODE_CONSTR: relax_pair(w.a, w.b, longint'(w.lo), longint'(w.hi));
            default: pending_reads.insert(pending_reads.size(), typed ? exp : mem[w.a]);
        endcase
    endtask

    task automatic add_row(input t_row row);
        plan.insert(plan.size(), row);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            vdcs_pkg::REG_DT_SQ: dt_sq  = data;
            vdcs_pkg::REG_GX:    grav_x = data;
            default:             grav_y = data;
        endcase
    endtask

    function automatic t_word mk(input logic [1:0] mode, input int a, input int b,
                                 input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] mass, input bit pin,
                                 input logic [30:0] lo, input logic [30:0] hi);
        t_word w;
        w = '{mode, a[9:0], b[9:0], px, py, mass, pin, lo, hi};
        return w;
    endfunction

    function automatic logic signed [31:0] rand_pos();
        if ($urandom_range(0, 9) < 8) return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
        return $urandom;
    endfunction

    initial begin
        t_snapshot none;
        t_snapshot p0;
        t_snapshot p1023;
        t_word     w;
        int        pool [24];
        logic [31:0] cfg_dt [6];
        logic [31:0] cfg_gx [6];
        logic [31:0] cfg_gy [6];
        int        r;

        none = '{0, 0, 0, 0, 0, 0};
        dt_sq  = vdcs_pkg::DT_SQ_RESET;
        grav_x = vdcs_pkg::GX_RESET;
        grav_y = vdcs_pkg::GY_RESET;
        p0    = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 1};
        p1023 = '{-32'sd1, 0, -32'sd1, 0, 32'd1, 0};

        add_row('{mk(vdcs_pkg::MODE_WRITE, 0, 0, p0.px, p0.py, p0.mass, 1, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, p0});
        add_row('{mk(vdcs_pkg::MODE_WRITE, 1023, 0, -1, 0, 1, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 1023, 0, 0, 0, 0, 0, 0, 0), 1, p1023});
        add_row('{mk(vdcs_pkg::MODE_INTEG, 1023, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 1023, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_INTEG, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, p0});
        // particle against itself
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, p0});
        // both masses zero
        add_row('{mk(vdcs_pkg::MODE_WRITE, 5, 0, 32'h10000, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_WRITE, 6, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 5, 6, 0, 0, 0, 0, 31'h20000, 31'h30000),
                  0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 5, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 6, 0, 0, 0, 0, 0, 0, 0), 0, none});
        // min above max
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 5, 6, 0, 0, 0, 0, 31'h40000, 31'h1000),
                  0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 6, 0, 0, 0, 0, 0, 0, 0), 0, none});
        // huge separation, only first pinned
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 0, 1023, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 1023, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 1023, 6, 0, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF),
                  0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 1023, 0, 0, 0, 0, 0, 0, 0), 0, none});
        // both pinned
        add_row('{mk(vdcs_pkg::MODE_WRITE, 7, 0, 32'h100000, 32'h100000, 32'h20000, 1, 0, 0),
                  0, none});
        add_row('{mk(vdcs_pkg::MODE_CONSTR, 7, 0, 0, 0, 0, 0, 0, 0), 0, none});
        add_row('{mk(vdcs_pkg::MODE_READ, 7, 0, 0, 0, 0, 0, 0, 0), 0, none});

        cfg_dt = '{32'd18, 32'hFFFFFFFF, 32'd0, 32'd65536, $urandom, $urandom_range(1, 32'h400)};
        cfg_gx = '{32'd0, 32'h7FFFFFFF, 32'h80000000, 32'd1000, $urandom, $urandom};
        cfg_gy = '{vdcs_pkg::GY_RESET, 32'h80000000, 32'h7FFFFFFF, vdcs_pkg::GY_RESET,
                   $urandom, $urandom};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send(plan[k].w, 34, plan[k].typed, plan[k].exp);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(vdcs_pkg::REG_DT_SQ, cfg_dt[ph]);
            write_reg(vdcs_pkg::REG_GX, cfg_gx[ph]);
            write_reg(vdcs_pkg::REG_GY, cfg_gy[ph]);
            foreach (pool[k]) pool[k] = (k < 2) ? k * 1023 : $urandom_range(0, 1023);
            for (int n = 0; n < 305; n++) begin
                r = $urandom_range(0, 99);
                w.a    = 10'(pool[$urandom_range(0, 23)]);
                w.b    = 10'(pool[$urandom_range(0, 23)]);
                w.px   = rand_pos();
                w.py   = rand_pos();
                w.mass = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 32'h40000)
                                                    : ($urandom | 32'd1);
                w.pin  = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    w.lo = 31'($urandom);
                    w.hi = 31'($urandom);
                end else begin
                    w.lo = 31'($urandom_range(0, 32'h200000));
                    w.hi = 31'(w.lo + $urandom_range(0, 32'h100000));
                end
                if (r < 15 || !written[w.a]) w.mode = vdcs_pkg::MODE_WRITE;
                else if (r < 35) w.mode = vdcs_pkg::MODE_INTEG;
                else if (r < 78) w.mode = vdcs_pkg::MODE_CONSTR;
                else w.mode = vdcs_pkg::MODE_READ;
                if (w.mode == vdcs_pkg::MODE_CONSTR && !written[w.b]) w.b = w.a;
                send(w, (ph == 3) ? 0 : 34, 0, none);
            end
        end

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/vdcs_pkg.sv
rtl/vdcs_ram.sv
rtl/vdcs_sqrt.sv
rtl/vdcs_div.sv
rtl/verlet_distance_constraint_solver.sv
sim/verlet_distance_constraint_solver_test.sv
